// ===== hdl/bba_pkg.sv =====
// Shared types and constants of the buddy block allocator.
`timescale 1ns / 1ps
package bba_pkg;

   localparam int ORDER_W = 5;
   localparam int HDR_W = 11;
   localparam logic [HDR_W-1:0] HEADER_RESET = 11'd32;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_OOM = 2'd1;
   localparam logic [1:0] ST_BAD_RELEASE = 2'd2;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [16:0] request_bytes;
      logic [15:0] release_address;
   } req_word_type;

   typedef struct packed {
      logic [15:0] payload_address;
      logic [1:0]  status;
   } rsp_word_type;

   typedef struct packed {
      logic [ORDER_W-1:0] order;
      logic               start;
      logic               free;
   } entry_type;

endpackage

// ===== hdl/bba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/bba_engine.sv =====
// Allocation and release sequencer over the granule table memory.
`timescale 1ns / 1ps
module bba_engine import bba_pkg::*; #(
   parameter int POOL_ORDER = 16,
   parameter int MIN_ORDER = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [HDR_W-1:0] header_bytes,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_word_type     req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_word_type     rsp_word
);

   localparam int GW = POOL_ORDER - MIN_ORDER;
   localparam int DEPTH = 1 << GW;
   localparam int GA = GW + 1;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_WALK_RD = 4'd2;
   localparam logic [3:0] S_WALK_CHK = 4'd3;
   localparam logic [3:0] S_SPLIT = 4'd4;
   localparam logic [3:0] S_REL_RD = 4'd5;
   localparam logic [3:0] S_REL_CHK = 4'd6;
   localparam logic [3:0] S_MRG_TST = 4'd7;
   localparam logic [3:0] S_MRG_RD = 4'd8;
   localparam logic [3:0] S_MRG_CHK = 4'd9;
   localparam logic [3:0] S_REL_WR = 4'd10;
   localparam logic [3:0] S_FIN = 4'd11;

   logic [3:0]         state_ff, state_in;
   logic [GW-1:0]      addr_ff, addr_in;
   logic [GW-1:0]      g_ff, g_in;
   logic [ORDER_W-1:0] k_ff, k_in;
   logic [ORDER_W-1:0] cur_o_ff, cur_o_in;
   logic               best_v_ff, best_v_in;
   rsp_word_type       res_ff, res_in;
   rsp_word_type       out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   logic               mem_we;
   logic [GW-1:0]      mem_waddr;
   entry_type          mem_wdata;
   entry_type          rdata;

   logic [17:0]        need;
   logic               k_found;
   logic [ORDER_W-1:0] k_val;
   logic [15:0]        off;
   logic               rel_ok;
   logic [GW-1:0]      rel_g;
   logic [GA-1:0]      step_rd, step_split, step_cur, next_g;
   logic [ORDER_W-1:0] o_m1;
   logic               accept;

   bba_ram #(.WIDTH($bits(entry_type)), .DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (addr_ff),
      .rdata (rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && !req_stall;

   always_comb begin
      need = 18'(req_word.request_bytes) + 18'(header_bytes);
      k_found = 1'b0;
      k_val = '0;
      for (int i = POOL_ORDER; i >= MIN_ORDER; i--) begin
         if ({14'd0, need} < (32'd1 << i)) begin
            k_found = 1'b1;
            k_val = ORDER_W'(i);
         end
      end
   end

   assign off = req_word.release_address - 16'(header_bytes);
   assign rel_ok = (req_word.release_address >= 16'(header_bytes))
                && ((32'(off) >> POOL_ORDER) == 32'd0)
                && (off[MIN_ORDER-1:0] == '0);
   assign rel_g = GW'(32'(off) >> MIN_ORDER);

   assign o_m1 = cur_o_ff - ORDER_W'(1);
   assign step_rd = GA'(1) << (rdata.order - ORDER_W'(MIN_ORDER));
   assign step_split = GA'(1) << (o_m1 - ORDER_W'(MIN_ORDER));
   assign step_cur = GA'(1) << (cur_o_ff - ORDER_W'(MIN_ORDER));
   assign next_g = {1'b0, addr_ff} + step_rd;

   always_comb begin
      state_in = state_ff;
      addr_in = addr_ff;
      g_in = g_ff;
      k_in = k_ff;
      cur_o_in = cur_o_ff;
      best_v_in = best_v_ff;
      res_in = res_ff;
      mem_we = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = '0;
      out_in = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = addr_ff;
            if (addr_ff == '0) begin
               mem_wdata = '{order: ORDER_W'(POOL_ORDER), start: 1'b1, free: 1'b1};
            end
            addr_in = addr_ff + GW'(1);
            if (addr_ff == GW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               res_in = '{payload_address: 16'd0, status: ST_OK};
               if (req_word.kind == KIND_ALLOC) begin
                  k_in = k_val;
                  best_v_in = 1'b0;
                  addr_in = '0;
                  if (k_found) begin
                     state_in = S_WALK_RD;
                  end else begin
                     res_in.status = ST_OOM;
                     state_in = S_FIN;
                  end
               end else if (rel_ok) begin
                  addr_in = rel_g;
                  g_in = rel_g;
                  state_in = S_REL_RD;
               end else begin
                  res_in.status = ST_BAD_RELEASE;
                  state_in = S_FIN;
               end
            end
         end
         S_WALK_RD: begin
            state_in = S_WALK_CHK;
         end
         S_WALK_CHK: begin
            if (rdata.free && rdata.order >= k_ff
                && (!best_v_ff || rdata.order < cur_o_ff)) begin
               best_v_in = 1'b1;
               g_in = addr_ff;
               cur_o_in = rdata.order;
            end
            if (next_g[GW]) begin
               if (best_v_in) begin
                  state_in = S_SPLIT;
               end else begin
                  res_in.status = ST_OOM;
                  state_in = S_FIN;
               end
            end else begin
               addr_in = next_g[GW-1:0];
               state_in = S_WALK_RD;
            end
         end
         S_SPLIT: begin
            mem_we = 1'b1;
            if (cur_o_ff > k_ff) begin
               mem_waddr = g_ff + step_split[GW-1:0];
               mem_wdata = '{order: o_m1, start: 1'b1, free: 1'b1};
               cur_o_in = o_m1;
            end else begin
               mem_waddr = g_ff;
               mem_wdata = '{order: k_ff, start: 1'b1, free: 1'b0};
               res_in.payload_address = 16'((32'(g_ff) << MIN_ORDER) + 32'(header_bytes));
               state_in = S_FIN;
            end
         end
         S_REL_RD: begin
            state_in = S_REL_CHK;
         end
         S_REL_CHK: begin
            if (!rdata.start || rdata.free) begin
               res_in.status = ST_BAD_RELEASE;
               state_in = S_FIN;
            end else begin
               cur_o_in = rdata.order;
               state_in = S_MRG_TST;
            end
         end
         S_MRG_TST: begin
            if (cur_o_ff < ORDER_W'(POOL_ORDER)) begin
               addr_in = g_ff ^ step_cur[GW-1:0];
               state_in = S_MRG_RD;
            end else begin
               state_in = S_REL_WR;
            end
         end
         S_MRG_RD: begin
            state_in = S_MRG_CHK;
         end
         S_MRG_CHK: begin
            if (rdata.start && rdata.free && rdata.order == cur_o_ff) begin
               mem_we = 1'b1;
               mem_waddr = (g_ff > addr_ff) ? g_ff : addr_ff;
               mem_wdata = '0;
               g_in = (g_ff < addr_ff) ? g_ff : addr_ff;
               cur_o_in = cur_o_ff + ORDER_W'(1);
               state_in = S_MRG_TST;
            end else begin
               state_in = S_REL_WR;
            end
         end
         S_REL_WR: begin
            mem_we = 1'b1;
            mem_waddr = g_ff;
            mem_wdata = '{order: cur_o_ff, start: 1'b1, free: 1'b1};
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_in = res_ff;
               out_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         out_valid_ff <= out_valid_in;
      end
      g_ff <= g_in;
      k_ff <= k_in;
      cur_o_ff <= cur_o_in;
      best_v_ff <= best_v_in;
      res_ff <= res_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word = out_ff;

endmodule

// ===== hdl/buddy_block_allocator.sv =====
// Top level of the buddy block allocator: register port and engine.
//
//  channel  direction  handshake                 word
//  req      in         req_valid / req_stall     req_word_type
//  rsp      out        rsp_valid / rsp_stall     rsp_word_type
//  csr      in/out     psel/penable/pwrite       header_bytes at byte 0
//
// Allocate: the walk reads and checks each pool block, then writes each split
// and the taken block. Release: read and check, then a test, buddy read and
// check per merge level, then a final write. The table has a single read port;
// one word is in flight at a time. After reset a clearing pass over the table
// ends first. A result waits in an output register under rsp_stall.
`timescale 1ns / 1ps
module buddy_block_allocator import bba_pkg::*; #(
   parameter int POOL_ORDER = 16,
   parameter int MIN_ORDER = 5
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   logic [HDR_W-1:0] header_ff;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HEADER_RESET;
      end else if (psel && penable && pwrite && pready && !paddr[2]) begin
         header_ff <= pwdata[HDR_W-1:0];
      end
   end

   assign prdata = paddr[2] ? 32'd0 : 32'(header_ff);

   bba_engine #(.POOL_ORDER(POOL_ORDER), .MIN_ORDER(MIN_ORDER)) u_engine (
      .clock        (clock),
      .reset        (reset),
      .header_bytes (header_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word     (rsp_word)
   );

endmodule

// ===== hdl/bba_checker.sv =====
// Port-level checks of the buddy block allocator, bound to the top level.
`timescale 1ns / 1ps
module bba_checker import bba_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word,
   input logic         pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.status == ST_OK || rsp_word.status == ST_OOM
                     || rsp_word.status == ST_BAD_RELEASE))
      else $error("undefined status code");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != ST_OK |-> rsp_word.payload_address == 16'd0)
      else $error("failed word carries an address");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word right after reset");

   a_ready: assert property (@(posedge clock) pready)
      else $error("pready low");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word),
   .pready    (pready)
);
